// ----- rtl/jnes_pkg.sv -----
package jnes_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    localparam int          ESC_LEN      = 6;
    localparam int          POS_W        = 3;
    localparam logic [2:0]  POS_MAX      = 3'd5;
    localparam int          QUEUE_DEPTH  = 4;

    // One classified input byte: replay `count` bytes of the escape prefix,
    // then the byte itself if emit_c is set. Nothing at all means a bare end marker.
    typedef struct packed {
        logic [7:0]       c;
        logic [POS_W-1:0] count;
        logic             emit_c;
        logic             last;
    } desc_t;

    function automatic logic [7:0] esc_char(input logic [POS_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_BACKSLASH;
            3'd1:    ch = CH_U;
            default: ch = CH_ZERO;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/jnes_if.sv -----
interface jnes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface jnes_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       text_done;

    modport source (output valid, output out_byte, output has_byte, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input text_done,
                    output ready);
endinterface

// ----- rtl/jnes_front.sv -----
module jnes_front
    import jnes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       push_valid,
    input  logic       push_ready,
    output desc_t      push_desc
);

    logic [POS_W-1:0] mp_reg, mp_next;
    logic             odd_reg, odd_next;

    logic [POS_W-1:0] flush_n;
    logic [POS_W-1:0] new_mp;
    logic             new_odd;
    logic             emit_c;
    logic             continued;
    logic             accept;

    always_comb
    begin
        flush_n   = '0;
        new_mp    = mp_reg;
        new_odd   = odd_reg;
        emit_c    = 1'b0;
        continued = 1'b0;

        if (mp_reg != '0 && mp_reg <= POS_MAX && data_byte == esc_char(mp_reg))
        begin
            continued = 1'b1;
            new_mp = (mp_reg == POS_W'(ESC_LEN - 1)) ? '0 : mp_reg + POS_W'(1);
        end
        else
        begin
            if (mp_reg != '0)
            begin
                // replay held prefix; only a lone backslash leaves an odd run
                flush_n = (mp_reg > POS_MAX) ? POS_MAX : mp_reg;
                new_odd = (mp_reg == POS_W'(1)) ? ~odd_reg : 1'b0;
                new_mp  = '0;
            end
            if (data_byte == CH_BACKSLASH && !new_odd)
            begin
                new_mp = POS_W'(1);
            end
            else
            begin
                emit_c  = 1'b1;
                new_odd = (data_byte == CH_BACKSLASH) ? ~new_odd : 1'b0;
            end
        end

        // end of text: release whatever is still held
        if (end_of_text && new_mp != '0)
        begin
            if (continued)
                flush_n = new_mp;
            else
                emit_c = 1'b1;
        end
    end

    assign push_desc = '{c: data_byte, count: flush_n, emit_c: emit_c, last: end_of_text};

    // drop items that give no result
    assign push_valid = valid && (end_of_text || emit_c || flush_n != '0);
    assign ready      = push_ready;
    assign accept     = valid && ready;

    always_comb
    begin
        mp_next  = mp_reg;
        odd_next = odd_reg;
        if (accept)
        begin
            mp_next  = end_of_text ? '0 : new_mp;
            odd_next = end_of_text ? 1'b0 : new_odd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg  <= '0;
            odd_reg <= 1'b0;
        end
        else
        begin
            mp_reg  <= mp_next;
            odd_reg <= odd_next;
        end
    end

endmodule

// ----- rtl/jnes_queue.sv -----
module jnes_queue
    import jnes_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_desc,
    output logic  pop_valid,
    input  logic  pop_ready,
    output desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_desc   = mem[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_desc;
    end

endmodule

// ----- rtl/jnes_back.sv -----
module jnes_back
    import jnes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    output logic       head_ready,
    input  desc_t      head,
    output logic       valid,
    input  logic       ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       text_done
);

    logic [POS_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             has_reg;
    logic             done_reg;

    logic [POS_W-1:0] n_res;
    logic [POS_W-1:0] last_idx;
    logic             at_last;
    logic             advance;
    logic             in_prefix;
    logic [7:0]       res_byte;
    logic             res_has;

    always_comb
    begin
        n_res = head.count + POS_W'(head.emit_c);
        if (n_res == '0)
            n_res = POS_W'(1);  // bare end marker
        last_idx = n_res - POS_W'(1);
    end

    assign at_last    = (idx_reg == last_idx);
    assign advance    = head_valid && (!valid_reg || ready);
    assign head_ready = advance && at_last;

    assign in_prefix = (idx_reg < head.count);
    assign res_has   = in_prefix || head.emit_c;
    assign res_byte  = in_prefix ? esc_char(idx_reg) : (head.emit_c ? head.c : 8'h00);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + POS_W'(1);
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= res_byte;
            has_reg  <= res_has;
            done_reg <= head.last && at_last;
        end
    end

    assign valid     = valid_reg;
    assign out_byte  = byte_reg;
    assign has_byte  = has_reg;
    assign text_done = done_reg;

endmodule

// ----- rtl/json_null_escape_stripper_top.sv -----
// An accepted item is written into the queue, and its first result is then registered into the output stage.
// Throughput: one item per cycle while items give at most one result each and the output is
// ready; an item with n results (n up to 6) holds the output stage until all are given, with up to
// QUEUE_DEPTH classified items buffered between the classifier and the output stage.
// Reset (rst_n low, asynchronous) clears match position, backslash parity, queue and
// output valid.
module json_null_escape_stripper_top
    import jnes_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    jnes_in_if.sink      text_ch,
    jnes_out_if.source   result_ch
);

    logic     push_valid;
    logic     push_ready;
    desc_t    push_desc;
    logic     head_valid;
    logic     head_ready;
    desc_t    head_desc;

    jnes_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (text_ch.valid),
        .ready       (text_ch.ready),
        .data_byte   (text_ch.data_byte),
        .end_of_text (text_ch.end_of_text),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_desc   (push_desc)
    );

    jnes_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_desc   (head_desc)
    );

    jnes_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head_desc),
        .valid      (result_ch.valid),
        .ready      (result_ch.ready),
        .out_byte   (result_ch.out_byte),
        .has_byte   (result_ch.has_byte),
        .text_done  (result_ch.text_done)
    );

endmodule
